// ----- src/vta_pkg.sv -----
package vta_pkg;

	// Operation of one request word
	typedef enum logic {
		OP_REF  = 1'b0,
		OP_DECL = 1'b1
	} op_t;

	// Result status
	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_MEM   = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	// Configuration register indexes
	typedef enum logic {
		REG_TABLE_LIMIT = 1'b0,
		REG_ARENA_LIMIT = 1'b1
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPEND1,
		ST_APPEND2,
		ST_APPEND3,
		ST_CHECK1,
		ST_CHECK2,
		ST_CHECK3,
		ST_FINISH
	} state_t;

	typedef logic [7:0]         name_t;
	typedef logic signed [15:0] num_t;

	// One variable table entry as stored in the entry memory
	typedef struct packed {
		logic [1:0]  dims;
		logic        str;
		name_t       n1;
		name_t       n0;
		logic [15:0] bd1;
		logic [15:0] bd0;
		logic [15:0] offset;
	} entry_t;

	// Element count limit and arena ceiling of the 16-bit address space
	localparam int unsigned MAX_ELEMS  = 65536;
	localparam int unsigned ADDR_SPACE = 65536;

endpackage

// ----- src/vta_req_if.sv -----
interface vta_req_if;
	import vta_pkg::*;

	logic        valid;
	logic        ready;
	op_t         opcode;
	name_t       name_first;
	name_t       name_second;
	logic        string_flag;
	logic [1:0]  subscript_count;
	num_t        first_number;
	num_t        second_number;

	modport source (
		output valid, opcode, name_first, name_second, string_flag,
		       subscript_count, first_number, second_number,
		input  ready
	);

	modport sink (
		input  valid, opcode, name_first, name_second, string_flag,
		       subscript_count, first_number, second_number,
		output ready
	);

endinterface

// ----- src/vta_rsp_if.sv -----
interface vta_rsp_if;
	import vta_pkg::*;

	logic        valid;
	logic        ready;
	err_t        status;
	logic [15:0] cell_address;
	logic        created;
	logic [15:0] region_start;
	logic [16:0] clear_length;

	modport source (
		output valid, status, cell_address, created, region_start, clear_length,
		input  ready
	);

	modport sink (
		input  valid, status, cell_address, created, region_start, clear_length,
		output ready
	);

endinterface

// ----- src/variable_table_allocator.sv -----
// Variable table allocator. Each request word is a reference (find the variable by
// name, kind and array-ness, creating it with implicit bounds if absent, then check
// the subscripts and return the cell address) or a declare (always append with the
// given bounds). Entries live in one synchronous entry memory that is searched one
// entry per cycle. A reference searches the table, appends on a miss, then checks the
// subscripts; a declare only appends, and stops early when it fails on table room or
// element count; a malformed request goes straight to the result. One request is in
// work at a time; the result sits in an output register, so the next request is taken
// while it waits. New regions are reported as region_start / clear_length for the
// arena owner to zero. Configuration goes through the APB port: table_limit at byte
// address 0, arena_limit at 4.
module variable_table_allocator #(
	parameter int TABLE_ENTRIES  = 64,
	parameter int ARENA_BYTES    = 65536,
	parameter int STRING_CHARS   = 31,
	parameter int IMPLICIT_BOUND = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	vta_req_if.sink     req,
	vta_rsp_if.source   rsp
);
	import vta_pkg::*;

	localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
	localparam int LIM_W      = (CNT_W > 7) ? CNT_W : 7;
	localparam int UNIT_BYTES = 1 + STRING_CHARS;
	localparam int UNIT_W     = $clog2(UNIT_BYTES + 1);
	localparam int BYTES_W    = 17 + UNIT_W;
	localparam int ARENA_CAP  = (ARENA_BYTES < ADDR_SPACE) ? ARENA_BYTES : ADDR_SPACE;

	// Configuration registers
	logic [6:0]  table_limit_q;
	logic [16:0] arena_limit_q;

	// Sequencer
	state_t state_q, state_d;

	// Latched request
	op_t         op_q;
	name_t       n0_q, n1_q;
	logic        str_q;
	logic [1:0]  cnt_q;
	logic [15:0] v0_q, v1_q;

	// Allocator state
	logic [CNT_W-1:0]  entry_count_q;
	logic [16:0]       bytes_used_q;

	// Entry memory
	entry_t mem [TABLE_ENTRIES];
	entry_t rd_data_q;
	logic   rd_en, wr_en;
	entry_t wr_data;

	// Search
	logic [CNT_W-1:0] search_q;
	logic             pend_q;
	logic             match;

	// Append datapath
	logic [15:0]        b0_q, b1_q;
	logic [33:0]        elems_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               full_q;
	logic               table_full;
	logic [16:0]        f0, f1;
	logic [LIM_W-1:0]   eff_table;
	logic [16:0]        eff_arena;
	logic [BYTES_W:0]   new_used;
	logic               arena_fail;
	logic [UNIT_W-1:0]  unit_new, unit_found;

	// Found entry and check datapath
	logic [1:0]  f_dims_q;
	logic        f_str_q;
	logic [15:0] f_bd0_q, f_bd1_q;
	logic [32:0] prod_q;
	logic [15:0] idx_q;
	logic        range_bad;

	// Result under construction
	err_t        err_q;
	logic [15:0] addr_q;
	logic        made_q;
	logic [15:0] start_q;
	logic [16:0] clr_q;

	// Output register
	logic        out_valid_q;
	err_t        out_err_q;
	logic [15:0] out_addr_q;
	logic        out_made_q;
	logic [15:0] out_start_q;
	logic [16:0] out_clr_q;

	logic req_fire, req_bad, out_load;

	// APB port: written on the access cycle, word select on paddr[2]
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_limit_q <= 7'd64;
			arena_limit_q <= 17'd65536;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[2]))
				REG_TABLE_LIMIT: table_limit_q <= pwdata[6:0];
				REG_ARENA_LIMIT: arena_limit_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_TABLE_LIMIT: prdata = {25'd0, table_limit_q};
			REG_ARENA_LIMIT: prdata = {15'd0, arena_limit_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Effective limits
	assign eff_table = (LIM_W'(table_limit_q) > LIM_W'(TABLE_ENTRIES)) ?
	                   LIM_W'(TABLE_ENTRIES) : LIM_W'(table_limit_q);
	assign eff_arena = (arena_limit_q > 17'(ARENA_CAP)) ? 17'(ARENA_CAP) : arena_limit_q;
	assign table_full = LIM_W'(entry_count_q) >= eff_table;

	// Request handshake and early rejection
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign req_bad   = (req.subscript_count == 2'd3) ||
	                   ((req.subscript_count != 2'd0) && req.first_number[15]) ||
	                   ((req.subscript_count == 2'd2) && req.second_number[15]);

	// Search compare against the entry read in the previous cycle
	assign rd_en = (state_q == ST_SEARCH) && (search_q < entry_count_q);
	assign match = pend_q && (rd_data_q.n0 == n0_q) && (rd_data_q.n1 == n1_q) &&
	               (rd_data_q.str == str_q) &&
	               ((rd_data_q.dims != 2'd0) == (cnt_q != 2'd0));

	// Append sizing
	assign f0 = (cnt_q != 2'd0) ? ({1'b0, b0_q} + 17'd1) : 17'd1;
	assign f1 = (cnt_q == 2'd2) ? ({1'b0, b1_q} + 17'd1) : 17'd1;
	assign unit_new   = str_q ? UNIT_W'(UNIT_BYTES) : UNIT_W'(2);
	assign unit_found = f_str_q ? UNIT_W'(UNIT_BYTES) : UNIT_W'(2);
	assign new_used   = (BYTES_W+1)'(bytes_used_q) + (BYTES_W+1)'(bytes_q);
	assign arena_fail = new_used > (BYTES_W+1)'(eff_arena);

	// New entry written on a successful append
	always_comb begin
		wr_data.dims   = cnt_q;
		wr_data.str    = str_q;
		wr_data.n1     = n1_q;
		wr_data.n0     = n0_q;
		wr_data.bd0    = (cnt_q != 2'd0) ? b0_q : 16'd0;
		wr_data.bd1    = (cnt_q == 2'd2) ? b1_q : 16'd0;
		wr_data.offset = bytes_used_q[15:0];
	end
	assign wr_en = (state_q == ST_APPEND3) && !arena_fail;

	// Subscript check of the found entry
	assign range_bad = (cnt_q != f_dims_q) ||
	                   ((cnt_q != 2'd0) && (v0_q > f_bd0_q)) ||
	                   ((cnt_q == 2'd2) && (v1_q > f_bd1_q));

	// Entry memory; write and search never overlap, one request at a time
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[entry_count_q[IDX_W-1:0]] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[search_q[IDX_W-1:0]];
	end

	// Output word load
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req_bad)
						state_d = ST_FINISH;
					else if (req.opcode == OP_DECL)
						state_d = ST_APPEND1;
					else
						state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (match)
					state_d = ST_CHECK1;
				else if (!rd_en && !pend_q)
					state_d = ST_APPEND1;
			end
			ST_APPEND1: state_d = ST_APPEND2;
			ST_APPEND2: begin
				if (full_q || (elems_q > 34'(MAX_ELEMS)))
					state_d = ST_FINISH;
				else
					state_d = ST_APPEND3;
			end
			ST_APPEND3: begin
				if (arena_fail || (op_q == OP_DECL))
					state_d = ST_FINISH;
				else
					state_d = ST_CHECK1;
			end
			ST_CHECK1: state_d = range_bad ? ST_FINISH : ST_CHECK2;
			ST_CHECK2: state_d = ST_CHECK3;
			ST_CHECK3: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Allocator control state and search pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			bytes_used_q  <= 17'd0;
			search_q      <= '0;
			pend_q        <= 1'b0;
		end else begin
			if (req_fire) begin
				search_q <= '0;
				pend_q   <= 1'b0;
			end else if (state_q == ST_SEARCH) begin
				pend_q <= rd_en;
				if (rd_en)
					search_q <= search_q + CNT_W'(1);
			end
			if (wr_en) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
				bytes_used_q  <= new_used[16:0];
			end
		end
	end

	// Datapath: latch request, size the region, check subscripts, build result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					op_q    <= req.opcode;
					n0_q    <= req.name_first;
					n1_q    <= req.name_second;
					str_q   <= req.string_flag;
					cnt_q   <= req.subscript_count;
					v0_q    <= req.first_number;
					v1_q    <= req.second_number;
					err_q   <= req_bad ? ERR_RANGE : ERR_OK;
					addr_q  <= 16'd0;
					made_q  <= 1'b0;
					start_q <= 16'd0;
					clr_q   <= 17'd0;
					if (req.opcode == OP_DECL) begin
						b0_q <= req.first_number;
						b1_q <= req.second_number;
					end else begin
						b0_q <= 16'(IMPLICIT_BOUND);
						b1_q <= 16'(IMPLICIT_BOUND);
					end
				end
			end
			ST_SEARCH: begin
				// Take the first matching entry as the found variable
				if (match) begin
					f_dims_q <= rd_data_q.dims;
					f_str_q  <= rd_data_q.str;
					f_bd0_q  <= rd_data_q.bd0;
					f_bd1_q  <= rd_data_q.bd1;
					start_q  <= rd_data_q.offset;
				end
			end
			ST_APPEND1: begin
				full_q  <= table_full;
				elems_q <= {17'd0, f0} * {17'd0, f1};
			end
			ST_APPEND2: begin
				if (full_q)
					err_q <= ERR_MEM;
				else if (elems_q > 34'(MAX_ELEMS))
					err_q <= ERR_RANGE;
				bytes_q <= BYTES_W'(elems_q[16:0]) * BYTES_W'(unit_new);
			end
			ST_APPEND3: begin
				if (arena_fail) begin
					err_q <= ERR_MEM;
				end else begin
					made_q   <= 1'b1;
					start_q  <= bytes_used_q[15:0];
					clr_q    <= bytes_q[16:0];
					f_dims_q <= wr_data.dims;
					f_str_q  <= wr_data.str;
					f_bd0_q  <= wr_data.bd0;
					f_bd1_q  <= wr_data.bd1;
					if (op_q == OP_DECL)
						addr_q <= bytes_used_q[15:0];
				end
			end
			ST_CHECK1: begin
				if (range_bad)
					err_q <= ERR_RANGE;
				prod_q <= 33'(v0_q * ({1'b0, f_bd1_q} + 17'd1));
			end
			ST_CHECK2: begin
				case (cnt_q)
					2'd2:    idx_q <= prod_q[15:0] + v1_q;
					2'd1:    idx_q <= v0_q;
					default: idx_q <= 16'd0;
				endcase
			end
			ST_CHECK3: begin
				addr_q <= start_q + 16'(idx_q * unit_found);
			end
			default: ;
		endcase
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_err_q   <= err_q;
			out_addr_q  <= addr_q;
			out_made_q  <= made_q;
			out_start_q <= start_q;
			out_clr_q   <= clr_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_err_q;
	assign rsp.cell_address = out_addr_q;
	assign rsp.created      = out_made_q;
	assign rsp.region_start = out_start_q;
	assign rsp.clear_length = out_clr_q;

endmodule

// ----- test/tb_variable_table_allocator.sv -----
`timescale 1ns / 100ps

package vta_tb_pkg;
	import vta_pkg::*;

	localparam int unsigned TABLE_ENTRIES  = 64;
	localparam int unsigned ARENA_BYTES    = 65536;
	localparam int unsigned STRING_CHARS   = 31;
	localparam int unsigned IMPLICIT_BOUND = 10;
	localparam int unsigned REPORT_LIMIT   = 10;

	// One request word as seen on the request channel
	typedef struct {
		op_t        opcode;
		name_t      name_first;
		name_t      name_second;
		logic       string_flag;
		logic [1:0] subscript_count;
		num_t       first_number;
		num_t       second_number;
	} request_t;

	// One result word as seen on the result channel
	typedef struct {
		err_t        status;
		logic [15:0] cell_address;
		logic        created;
		logic [15:0] region_start;
		logic [16:0] clear_length;
	} result_t;

	// Shadow of the variable table with the queue of results it predicts
	class allocation_scoreboard;
		logic [18:0] keys [TABLE_ENTRIES];
		logic [31:0] bounds [TABLE_ENTRIES];
		logic [15:0] offsets [TABLE_ENTRIES];
		logic [6:0]  entry_count;
		logic [16:0] bytes_used;
		logic [6:0]  table_limit;
		logic [16:0] arena_limit;
		result_t     expected_results [$];
		int unsigned mismatches;

		function new();
			entry_count = 0;
			bytes_used  = 0;
			table_limit = 7'd64;
			arena_limit = 17'd65536;
			mismatches  = 0;
		endfunction

		function void set_limit(reg_idx_t idx, logic [31:0] value);
			if (idx == REG_TABLE_LIMIT) table_limit = value[6:0];
			else arena_limit = value[16:0];
		endfunction

		function int unsigned table_room();
			return (table_limit > TABLE_ENTRIES) ? TABLE_ENTRIES : table_limit;
		endfunction

		function int unsigned arena_room();
			int unsigned room;
			room = arena_limit;
			if (room > ARENA_BYTES) room = ARENA_BYTES;
			if (room > ADDR_SPACE) room = ADDR_SPACE;
			return room;
		endfunction

		function int unsigned cell_bytes(logic str_kind);
			return str_kind ? (1 + STRING_CHARS) : 2;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Append an entry at the end of the table and bump the arena pointer
		function err_t append_entry(logic [18:0] key, int unsigned b0, int unsigned b1,
			output int unsigned slot, output int unsigned length);
			int unsigned elems;
			int unsigned bytes;
			logic [1:0]  dims;
			dims   = key[18:17];
			elems  = 1;
			slot   = 0;
			length = 0;
			if (entry_count >= table_room()) return ERR_MEM;
			if (dims > 0) begin
				elems = elems * (b0 + 1);
				if (elems > MAX_ELEMS) return ERR_RANGE;
			end
			if (dims > 1) begin
				elems = elems * (b1 + 1);
				if (elems > MAX_ELEMS) return ERR_RANGE;
			end
			bytes = elems * cell_bytes(key[16]);
			if (bytes_used + bytes > arena_room()) return ERR_MEM;
			slot = 32'(entry_count);
			keys[slot]    = key;
			bounds[slot]  = {(dims > 1) ? b1[15:0] : 16'd0, (dims > 0) ? b0[15:0] : 16'd0};
			offsets[slot] = bytes_used[15:0];
			entry_count   = entry_count + 7'd1;
			bytes_used    = 17'(bytes_used + bytes);
			length        = bytes;
			return ERR_OK;
		endfunction

		// Predict the result of one accepted request and queue it
		function void note_request(request_t r);
			result_t     want;
			int unsigned v0, v1, slot, length, idx, bd0, bd1;
			bit          found;
			logic [1:0]  dims;
			want  = '{ERR_OK, 16'd0, 1'b0, 16'd0, 17'd0};
			v0    = {16'd0, r.first_number};
			v1    = {16'd0, r.second_number};
			slot  = 0;
			found = 0;
			if (r.subscript_count == 2'd3 || (r.subscript_count > 0 && v0[15]) ||
				(r.subscript_count > 1 && v1[15])) begin
				want.status = ERR_RANGE;
			end else if (r.opcode == OP_DECL) begin
				want.status = append_entry({r.subscript_count, r.string_flag,
					r.name_second, r.name_first}, v0, v1, slot, length);
				if (want.status == ERR_OK) begin
					want.created      = 1'b1;
					want.region_start = offsets[slot];
					want.cell_address = offsets[slot];
					want.clear_length = 17'(length);
				end
			end else begin
				// Search on name and kind, scalar versus array
				for (int unsigned i = 0; i < entry_count && !found; i++) begin
					if (keys[i][16:0] == {r.string_flag, r.name_second, r.name_first} &&
						((keys[i][18:17] != 0) == (r.subscript_count != 0))) begin
						slot  = i;
						found = 1;
					end
				end
				if (!found) begin
					want.status = append_entry({r.subscript_count, r.string_flag,
						r.name_second, r.name_first}, IMPLICIT_BOUND, IMPLICIT_BOUND,
						slot, length);
					if (want.status == ERR_OK) begin
						want.created      = 1'b1;
						want.clear_length = 17'(length);
						found             = 1;
					end
				end
				if (found) begin
					dims = keys[slot][18:17];
					bd0  = bounds[slot][15:0];
					bd1  = bounds[slot][31:16];
					idx  = 0;
					want.region_start = offsets[slot];
					if (r.subscript_count != dims) begin
						want.status = ERR_RANGE;
					end else begin
						if (r.subscript_count > 0) begin
							if (v0 > bd0) want.status = ERR_RANGE;
							else idx = v0;
						end
						if (want.status == ERR_OK && r.subscript_count > 1) begin
							if (v1 > bd1) want.status = ERR_RANGE;
							else idx = idx * (bd1 + 1) + v1;
						end
					end
					if (want.status == ERR_OK)
						want.cell_address = 16'(offsets[slot] + idx * cell_bytes(keys[slot][16]));
				end
			end
			expected_results.push_back(want);
		endfunction

		function string show(result_t x);
			return $sformatf("err=%0d addr=%h created=%0d start=%h clear=%h",
				x.status, x.cell_address, x.created, x.region_start, x.clear_length);
		endfunction

		// Compare one result word with the oldest prediction
		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result with nothing pending: %s", show(got));
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status || got.cell_address !== want.cell_address ||
				got.created !== want.created || got.region_start !== want.region_start ||
				got.clear_length !== want.clear_length) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected %s, got %s", show(want), show(got));
			end
		endfunction
	endclass

endpackage

module tb_variable_table_allocator;
	import vta_pkg::*;
	import vta_tb_pkg::*;

	localparam int unsigned LATENCY_CYCLES = 80;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned PHASE_ITEMS    = 610;
	localparam int unsigned CYCLE_LIMIT    = 1000000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	vta_req_if request_bus ();
	vta_rsp_if result_bus ();

	allocation_scoreboard board;
	int unsigned          send_idle_pct = 31;
	int unsigned          take_idle_pct = 73;
	bit                   hold_armed = 0;
	bit                   hold_done = 0;
	int unsigned          hold_left = 0;
	int unsigned          cycle_count = 0;

	variable_table_allocator #(
		.TABLE_ENTRIES  (TABLE_ENTRIES),
		.ARENA_BYTES    (ARENA_BYTES),
		.STRING_CHARS   (STRING_CHARS),
		.IMPLICIT_BOUND (IMPLICIT_BOUND)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (request_bus),
		.rsp     (result_bus)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Take result words, with random idling and one long hold-off
	initial begin
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= take_idle_pct);
			end
		end
	end

	// Watch both channels: check results, then predict new requests
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			board.check_result(result_t'{result_bus.status, result_bus.cell_address,
				result_bus.created, result_bus.region_start, result_bus.clear_length});
		if (arst_n && request_bus.valid && request_bus.ready)
			board.note_request(request_t'{request_bus.opcode, request_bus.name_first,
				request_bus.name_second, request_bus.string_flag,
				request_bus.subscript_count, request_bus.first_number,
				request_bus.second_number});
	end

	// Write one register through the APB port
	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_limit(idx, value);
		@(posedge clk);
	endtask

	// Offer one request word, holding it until accepted
	task automatic send_request(input request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			request_bus.valid <= 1'b0;
			@(posedge clk);
		end
		request_bus.valid           <= 1'b1;
		request_bus.opcode          <= r.opcode;
		request_bus.name_first      <= r.name_first;
		request_bus.name_second     <= r.name_second;
		request_bus.string_flag     <= r.string_flag;
		request_bus.subscript_count <= r.subscript_count;
		request_bus.first_number    <= r.first_number;
		request_bus.second_number   <= r.second_number;
		@(posedge clk);
		while (!request_bus.ready) @(posedge clk);
	endtask

	task automatic send_fields(input op_t op, input name_t n0, input name_t n1,
		input logic str, input logic [1:0] cnt, input num_t v0, input num_t v1);
		send_request(request_t'{op, n0, n1, str, cnt, v0, v1});
	endtask

	// Drop valid and wait until every result is back and the block is quiet
	task automatic settle();
		request_bus.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	function automatic num_t random_number(input op_t op);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return (op == OP_DECL) ? num_t'($urandom_range(20)) : num_t'($urandom_range(12));
		if (pick < 85) return num_t'($urandom_range(400));
		return num_t'($urandom_range(32767));
	endfunction

	// Mostly well-formed requests over a small name pool, some noise and broken words
	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			r.opcode          = op_t'($urandom_range(1));
			r.name_first      = 8'($urandom);
			r.name_second     = 8'($urandom);
			r.string_flag     = 1'($urandom_range(1));
			r.subscript_count = 2'($urandom_range(3));
			r.first_number    = 16'($urandom);
			r.second_number   = 16'($urandom);
		end else begin
			r.opcode = (pick < 20) ? OP_DECL : OP_REF;
			case ($urandom_range(3))
				0: r.name_first = 8'h00;
				1: r.name_first = 8'h41;
				2: r.name_first = 8'h5A;
				default: r.name_first = 8'hFF;
			endcase
			r.name_second     = $urandom_range(1) ? 8'h39 : 8'h00;
			r.string_flag     = 1'($urandom_range(1));
			r.subscript_count = 2'($urandom_range(2));
			r.first_number    = random_number(r.opcode);
			r.second_number   = random_number(r.opcode);
			if (pick >= 94) begin
				case ($urandom_range(2))
					0: r.subscript_count = 2'd3;
					1: begin
						r.subscript_count = 2'd1;
						r.first_number[15] = 1'b1;
					end
					default: begin
						r.subscript_count = 2'd2;
						r.second_number[15] = 1'b1;
					end
				endcase
			end
		end
		return r;
	endfunction

	initial begin
		board = new();
		arst_n                      <= 1'b0;
		psel                        <= 1'b0;
		penable                     <= 1'b0;
		pwrite                      <= 1'b0;
		paddr                       <= '0;
		pwdata                      <= '0;
		request_bus.valid           <= 1'b0;
		request_bus.opcode          <= OP_REF;
		request_bus.name_first      <= '0;
		request_bus.name_second     <= '0;
		request_bus.string_flag     <= 1'b0;
		request_bus.subscript_count <= '0;
		request_bus.first_number    <= '0;
		request_bus.second_number   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No table room: creates fail, malformed words are rejected first
		write_register(REG_TABLE_LIMIT, 32'd0);
		write_register(REG_ARENA_LIMIT, 32'h1FFFF);
		send_fields(OP_REF, 8'h41, 8'h41, 1'b0, 2'd0, 16'sd0, 16'sd0);
		send_fields(OP_DECL, 8'h41, 8'h41, 1'b0, 2'd3, 16'sd1, 16'sd1);
		send_fields(OP_REF, 8'h41, 8'h41, 1'b0, 2'd1, -16'sd1, 16'sd0);
		send_fields(OP_REF, 8'h41, 8'h41, 1'b1, 2'd2, 16'sd0, -16'sd32768);
		settle();

		// No arena room
		write_register(REG_TABLE_LIMIT, 32'd127);
		write_register(REG_ARENA_LIMIT, 32'd0);
		send_fields(OP_DECL, 8'h41, 8'h41, 1'b0, 2'd0, 16'sd0, 16'sd0);
		settle();

		// Default room: element limit, arena overflow, lookup and addressing cases
		write_register(REG_TABLE_LIMIT, 32'd64);
		write_register(REG_ARENA_LIMIT, 32'd65536);
		send_fields(OP_DECL, 8'h41, 8'h41, 1'b0, 2'd2, 16'sd255, 16'sd256);
		send_fields(OP_DECL, 8'h41, 8'h41, 1'b1, 2'd2, 16'sd255, 16'sd255);
		send_fields(OP_DECL, 8'h41, 8'h41, 1'b0, 2'd2, 16'sd32767, 16'sd1);
		send_fields(OP_DECL, 8'h00, 8'h00, 1'b0, 2'd0, 16'sd0, 16'sd0);
		send_fields(OP_REF, 8'h00, 8'h00, 1'b0, 2'd0, 16'sd0, 16'sd0);
		send_fields(OP_REF, 8'hFF, 8'hFF, 1'b1, 2'd1, 16'sd10, 16'sd0);
		send_fields(OP_REF, 8'hFF, 8'hFF, 1'b1, 2'd1, 16'sd11, 16'sd0);
		send_fields(OP_REF, 8'h41, 8'h42, 1'b0, 2'd2, 16'sd3, 16'sd11);
		send_fields(OP_REF, 8'h41, 8'h42, 1'b0, 2'd1, 16'sd3, 16'sd0);
		send_fields(OP_DECL, 8'h43, 8'h00, 1'b0, 2'd1, 16'sd5, 16'sd0);
		send_fields(OP_DECL, 8'h43, 8'h00, 1'b0, 2'd1, 16'sd7, 16'sd0);
		send_fields(OP_REF, 8'h43, 8'h00, 1'b0, 2'd1, 16'sd6, 16'sd0);
		send_fields(OP_REF, 8'h43, 8'h00, 1'b0, 2'd1, 16'sd5, 16'sd0);
		send_fields(OP_REF, 8'h41, 8'h42, 1'b0, 2'd2, 16'sd10, 16'sd10);
		send_fields(OP_DECL, 8'h5A, 8'h00, 1'b1, 2'd0, 16'sd0, 16'sd0);
		send_fields(OP_REF, 8'h5A, 8'h00, 1'b1, 2'd0, -16'sd32768, -16'sd1);
		send_fields(OP_DECL, 8'h44, 8'hFF, 1'b1, 2'd1, 16'sd0, 16'sd0);

		// Random phases with different room and idling on each side
		for (int phase = 0; phase < 3; phase++) begin
			settle();
			case (phase)
				0: begin
					write_register(REG_TABLE_LIMIT, 32'd24);
					write_register(REG_ARENA_LIMIT, 32'd12000);
					send_idle_pct = 31;
					take_idle_pct = 73;
				end
				1: begin
					write_register(REG_TABLE_LIMIT, 32'd48);
					write_register(REG_ARENA_LIMIT, 32'd40000);
					send_idle_pct = 73;
					take_idle_pct = 31;
				end
				default: begin
					write_register(REG_TABLE_LIMIT, 32'd127);
					write_register(REG_ARENA_LIMIT, 32'd65536);
					send_idle_pct = 0;
					take_idle_pct = 0;
					hold_armed    = 1;
				end
			endcase
			repeat (PHASE_ITEMS) send_request(random_request());
		end

		settle();
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/vta_pkg.sv
src/vta_req_if.sv
src/vta_rsp_if.sv
src/variable_table_allocator.sv
test/tb_variable_table_allocator.sv
